// File: src/qsf_pkg.sv
package qsf_pkg;

    localparam int CompWidth = 16;
    localparam int FracBits = 14;
    localparam int AlphaWidth = 16;
    localparam int FloorWidth = 31;
    localparam int SeqWidth = 32;
    localparam int SumWidth = 2 * CompWidth + 2;
    localparam int RootWidth = SumWidth / 2;
    localparam int QuotWidth = CompWidth + FracBits;
    localparam int QueueDepth = 2;

    localparam logic [AlphaWidth-1:0] AlphaReset = AlphaWidth'(58982);
    localparam logic [FloorWidth-1:0] FloorReset = FloorWidth'(1000);

    typedef enum logic [0:0] {
        REG_ALPHA = 1'b0,
        REG_FLOOR = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic signed [CompWidth-1:0] w;
        logic signed [CompWidth-1:0] x;
        logic signed [CompWidth-1:0] y;
        logic signed [CompWidth-1:0] z;
    } quat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLEND,
        ST_SQUARE,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

// File: src/quaternion_smoothing_filter_unit.sv
// Quaternion smoothing filter. Each transfer on the s_ side carries a Q1.14
// quaternion and a signed sequence counter; samples whose counter is neither
// above the last kept one nor below counter_floor are dropped with no result.
// A kept sample is blended with the previous output using alpha (Q0.16),
// normalized with a bit-serial square root and four bit-serial divides, and
// delivered on the m_ side. In the back end a kept sample is taken from the
// queue, blended and squared lane by lane over its four components, put
// through 17 root steps and 4 divides (each a load and 30 quotient bits),
// and placed in the output register, which waits while the previous result
// has not been taken. A two-entry queue lets the input side keep accepting.
module quaternion_smoothing_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // in_w, in_x, in_y, in_z, seq_counter
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_w, out_x, out_y, out_z
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);
    import qsf_pkg::*;

    logic [AlphaWidth-1:0] alpha_reg;
    logic [FloorWidth-1:0] floor_reg;
    logic  q_valid, q_ready;
    quat_t s_quat, q_quat, m_quat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= AlphaReset;
            floor_reg <= FloorReset;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_ALPHA: alpha_reg <= cfg_data[AlphaWidth-1:0];
                REG_FLOOR: floor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_quat = '{w: s_tdata[15:0], x: s_tdata[31:16],
                      y: s_tdata[47:32], z: s_tdata[63:48]};
    assign m_tdata = {m_quat.z, m_quat.y, m_quat.x, m_quat.w};

    qsf_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_quat,
        .s_seq(s_tdata[95:64]), .counter_floor(floor_reg),
        .q_valid, .q_ready, .q_quat
    );

    qsf_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_quat,
        .alpha(alpha_reg), .m_tvalid, .m_tready, .m_quat
    );
endmodule

// File: src/qsf_front.sv
module qsf_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  qsf_pkg::quat_t                  s_quat,
    input  logic [qsf_pkg::SeqWidth-1:0]    s_seq,
    input  logic [qsf_pkg::FloorWidth-1:0]  counter_floor,
    output logic                            q_valid,
    input  logic                            q_ready,
    output qsf_pkg::quat_t                  q_quat
);
    import qsf_pkg::*;

    logic signed [SeqWidth-1:0] last_counter_reg, last_counter_next;
    quat_t                      mem_reg [QueueDepth];
    logic                       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                 count_reg;
    logic                       keep, push, pop;

    // Signed compare against the last kept counter; the floor compare is
    // done on the signed value against a nonnegative floor.
    always_comb begin
        keep = ($signed(s_seq) > last_counter_reg) ||
               ($signed(s_seq) < $signed({1'b0, counter_floor}));
        last_counter_next = last_counter_reg;
        if (s_tvalid && s_tready && keep) begin
            last_counter_next = $signed(s_seq);
        end
    end

    assign s_tready = (count_reg != 2'(QueueDepth));
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_quat   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_counter_reg <= '1;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            count_reg        <= 2'd0;
        end else begin
            last_counter_reg <= last_counter_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_quat;
        end
    end
endmodule

// File: src/qsf_back.sv
module qsf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  qsf_pkg::quat_t                  q_quat,
    input  logic [qsf_pkg::AlphaWidth-1:0]  alpha,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output qsf_pkg::quat_t                  m_quat
);
    import qsf_pkg::*;

    back_state_t state_reg, state_next;
    quat_t       prev_reg, new_reg, blend_reg, res_reg, out_reg;
    logic        have_prev_reg;
    logic [1:0]  lane_reg;
    logic [SumWidth-1:0]  sum_reg, rem_reg;
    logic [RootWidth-1:0] root_reg;
    logic [5:0]           bit_reg;
    logic [QuotWidth-1:0] num_reg, quot_reg;
    logic [RootWidth:0]   drem_reg;
    logic                 valid_reg;

    logic signed [CompWidth-1:0] cur_new, cur_prev, cur_blend;
    logic signed [CompWidth+AlphaWidth+2:0] mix;
    logic [CompWidth-1:0]   mag;
    logic [2*CompWidth-1:0] sq;
    logic [RootWidth:0]     dtrial;
    logic [QuotWidth-1:0]   quot_step;
    logic signed [CompWidth+FracBits:0] sres;
    logic signed [CompWidth-1:0]        sat;

    always_comb begin
        unique case (lane_reg)
            2'd0: begin cur_new = new_reg.w; cur_prev = prev_reg.w; cur_blend = blend_reg.w; end
            2'd1: begin cur_new = new_reg.x; cur_prev = prev_reg.x; cur_blend = blend_reg.x; end
            2'd2: begin cur_new = new_reg.y; cur_prev = prev_reg.y; cur_blend = blend_reg.y; end
            default: begin cur_new = new_reg.z; cur_prev = prev_reg.z; cur_blend = blend_reg.z; end
        endcase
        mix = $signed({1'b0, alpha}) * cur_new
            + ($signed({1'b0, 17'h10000}) - $signed({2'b0, alpha})) * cur_prev;
        mag = cur_blend[CompWidth-1] ? CompWidth'(-cur_blend) : CompWidth'(cur_blend);
        sq  = mag * mag;
        dtrial = {drem_reg[RootWidth-1:0], num_reg[QuotWidth-1]} - {1'b0, root_reg};
        // Quotient including the bit decided in this cycle.
        quot_step = {quot_reg[QuotWidth-2:0], ~dtrial[RootWidth]};
        sres = cur_blend[CompWidth-1] ? -$signed({1'b0, quot_step})
                                      : $signed({1'b0, quot_step});
        if (sres > $signed((CompWidth+FracBits+1)'(2**(CompWidth-1) - 1))) begin
            sat = {1'b0, {(CompWidth-1){1'b1}}};
        end else if (sres < -$signed((CompWidth+FracBits+1)'(2**(CompWidth-1)))) begin
            sat = {1'b1, {(CompWidth-1){1'b0}}};
        end else begin
            sat = CompWidth'(sres);
        end
    end

    always_comb begin
        state_next = state_reg;
        q_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_BLEND;
            ST_BLEND:  if (lane_reg == 2'd3) state_next = ST_SQUARE;
            ST_SQUARE: if (lane_reg == 2'd3) state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg == 6'd0) state_next = ST_DIV;
            ST_DIV:    if (bit_reg == 6'd0 && lane_reg == 2'd3) state_next = ST_OUT;
            ST_OUT:    if (!valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_quat   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            valid_reg     <= 1'b0;
            prev_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && (!valid_reg || m_tready)) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    lane_reg <= 2'd0;
                    new_reg  <= q_quat;
                    if (q_valid && !have_prev_reg) begin
                        prev_reg <= q_quat;
                    end
                    if (q_valid) begin
                        have_prev_reg <= 1'b1;
                    end
                end
                ST_BLEND: begin
                    unique case (lane_reg)
                        2'd0: blend_reg.w <= CompWidth'(mix >>> AlphaWidth);
                        2'd1: blend_reg.x <= CompWidth'(mix >>> AlphaWidth);
                        2'd2: blend_reg.y <= CompWidth'(mix >>> AlphaWidth);
                        default: blend_reg.z <= CompWidth'(mix >>> AlphaWidth);
                    endcase
                    lane_reg <= lane_reg + 2'd1;
                    sum_reg  <= '0;
                end
                ST_SQUARE: begin
                    sum_reg  <= sum_reg + SumWidth'(sq);
                    lane_reg <= lane_reg + 2'd1;
                    root_reg <= '0;
                    bit_reg  <= 6'(RootWidth - 1);
                    rem_reg  <= '0;
                end
                ST_SQRT: begin
                    // Remainder takes in two bits of the radicand per step.
                    if ({rem_reg[SumWidth-3:0], sum_reg[2*bit_reg+1 -: 2]} >=
                        {root_reg[RootWidth-2:0], 2'b01}) begin
                        rem_reg  <= {rem_reg[SumWidth-3:0], sum_reg[2*bit_reg+1 -: 2]}
                                  - SumWidth'({root_reg[RootWidth-2:0], 2'b01});
                        root_reg <= {root_reg[RootWidth-2:0], 1'b1};
                    end else begin
                        rem_reg  <= {rem_reg[SumWidth-3:0], sum_reg[2*bit_reg+1 -: 2]};
                        root_reg <= {root_reg[RootWidth-2:0], 1'b0};
                    end
                    if (bit_reg != 6'd0) begin
                        bit_reg <= bit_reg - 6'd1;
                    end else begin
                        bit_reg  <= 6'(QuotWidth);
                        lane_reg <= 2'd0;
                    end
                    drem_reg <= '0;
                    num_reg  <= '0;
                    quot_reg <= '0;
                end
                ST_DIV: begin
                    if (bit_reg == 6'(QuotWidth)) begin
                        num_reg  <= {mag, {FracBits{1'b0}}};
                        drem_reg <= '0;
                        quot_reg <= '0;
                        bit_reg  <= bit_reg - 6'd1;
                    end else begin
                        if (!dtrial[RootWidth]) begin
                            drem_reg <= dtrial;
                        end else begin
                            drem_reg <= {drem_reg[RootWidth-1:0], num_reg[QuotWidth-1]};
                        end
                        quot_reg <= quot_step;
                        num_reg  <= {num_reg[QuotWidth-2:0], 1'b0};
                        if (bit_reg != 6'd0) begin
                            bit_reg <= bit_reg - 6'd1;
                        end
                    end
                    if (bit_reg == 6'd0) begin
                        unique case (lane_reg)
                            2'd0: res_reg.w <= sat;
                            2'd1: res_reg.x <= sat;
                            2'd2: res_reg.y <= sat;
                            default: res_reg.z <= sat;
                        endcase
                        lane_reg <= lane_reg + 2'd1;
                        bit_reg  <= 6'(QuotWidth);
                    end
                end
                ST_OUT: begin
                    if (!valid_reg || m_tready) begin
                        if (sum_reg == '0) begin
                            out_reg  <= '{w: CompWidth'(2**FracBits), x: '0, y: '0, z: '0};
                            prev_reg <= '{w: CompWidth'(2**FracBits), x: '0, y: '0, z: '0};
                        end else begin
                            out_reg  <= res_reg;
                            prev_reg <= res_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: bench/tb_quaternion_smoothing_filter_unit.sv
module tb_quaternion_smoothing_filter_unit;
    import qsf_pkg::*;

    localparam int LatencyCycles = 120;
    localparam int WatchdogLimit = 20000;

    typedef struct {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } orient_t;

    class orientation_scoreboard;
        logic [15:0] alpha_q16;
        logic [30:0] floor_cnt;
        longint prev_w, prev_x, prev_y, prev_z;
        bit primed;
        int last_kept;
        orient_t pending[$];
        int errors;

        function void clear_state();
            alpha_q16 = AlphaReset;
            floor_cnt = FloorReset;
            prev_w = 0; prev_x = 0; prev_y = 0; prev_z = 0;
            primed = 0;
            last_kept = -1;
            errors = 0;
            pending.delete();
        endfunction

        function void write_reg(reg_index_t idx, logic [30:0] value);
            if (idx == REG_ALPHA) alpha_q16 = value[15:0];
            else floor_cnt = value;
        endfunction

        static function longint blend(longint a, longint nv, longint pv);
            longint t;
            t = a * nv + (65536 - a) * pv;
            return t >>> 16;
        endfunction

        static function longint clamp(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        static function longint unit_scale(longint b, longint root);
            longint q;
            q = ((b < 0 ? -b : b) << FracBits) / root;
            return clamp(b < 0 ? -q : q);
        endfunction

        function void note_sample(logic [95:0] item);
            longint nw, nx, ny, nz, seq, bw, bx, by, bz, a;
            longint unsigned sum, root, cand;
            orient_t res;
            nw = $signed(item[15:0]);
            nx = $signed(item[31:16]);
            ny = $signed(item[47:32]);
            nz = $signed(item[63:48]);
            seq = $signed(item[95:64]);
            a = alpha_q16;
            if (!(seq > last_kept || seq < longint'(floor_cnt))) return;
            last_kept = int'(seq);
            if (!primed) begin
                prev_w = nw; prev_x = nx; prev_y = ny; prev_z = nz;
                primed = 1;
            end
            bw = blend(a, nw, prev_w);
            bx = blend(a, nx, prev_x);
            by = blend(a, ny, prev_y);
            bz = blend(a, nz, prev_z);
            sum = bw * bw + bx * bx + by * by + bz * bz;
            if (sum == 0) begin
                prev_w = clamp(longint'(1) << FracBits);
                prev_x = 0; prev_y = 0; prev_z = 0;
            end else begin
                root = 0;
                for (int i = 31; i >= 0; i--) begin
                    cand = root | (64'd1 << i);
                    if (cand * cand <= sum) root = cand;
                end
                prev_w = unit_scale(bw, root);
                prev_x = unit_scale(bx, root);
                prev_y = unit_scale(by, root);
                prev_z = unit_scale(bz, root);
            end
            res.w = 16'(prev_w); res.x = 16'(prev_x);
            res.y = 16'(prev_y); res.z = 16'(prev_z);
            pending.push_back(res);
        endfunction

        function void check_result(logic [63:0] data);
            orient_t exp_q;
            if (pending.size() == 0) begin
                $error("unexpected result %h", data);
                errors++;
                return;
            end
            exp_q = pending.pop_front();
            if (data[15:0] !== exp_q.w) begin
                $error("out_w expected %0d actual %0d", exp_q.w, $signed(data[15:0]));
                errors++;
            end
            if (data[31:16] !== exp_q.x) begin
                $error("out_x expected %0d actual %0d", exp_q.x, $signed(data[31:16]));
                errors++;
            end
            if (data[47:32] !== exp_q.y) begin
                $error("out_y expected %0d actual %0d", exp_q.y, $signed(data[47:32]));
                errors++;
            end
            if (data[63:48] !== exp_q.z) begin
                $error("out_z expected %0d actual %0d", exp_q.z, $signed(data[63:48]));
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [63:0] m_tdata;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [30:0] cfg_data = '0;

    orientation_scoreboard board;
    int idle_cycles;
    bit hold_off_req;
    int seq_now;

    quaternion_smoothing_filter_unit i_dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // Inputs are scored at the same rising edge where the transfer happens.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_sample(s_tdata);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stalls, with one long hold-off on request.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                stall = 600;
                hold_off_req = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = $urandom_range(0, 19);
            end else begin
                stall = 0;
            end
            if (stall != 0) begin
                m_tready <= 0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    task automatic write_cfg(reg_index_t idx, logic [30:0] value);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 0;
        board.write_reg(idx, value);
    endtask

    // Leaves s_tvalid high after the transfer; the next call or drain() changes it.
    task automatic send_sample(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                               logic [15:0] z, logic [31:0] seq, bit gaps);
        int gap;
        gap = 0;
        if (gaps && $urandom_range(0, 2) == 0) gap = $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {seq, z, y, x, w};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (LatencyCycles) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int count, bit gaps);
        logic [31:0] seq;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0: seq = $urandom();
                1: seq = seq_now - $urandom_range(1, 5);
                2: seq = $urandom_range(0, 2000);
                default: begin
                    seq_now += $urandom_range(1, 3);
                    seq = seq_now;
                end
            endcase
            if ($signed(seq) > seq_now) seq_now = seq;
            send_sample(rand_comp(), rand_comp(), rand_comp(), rand_comp(), seq, gaps);
        end
    endtask

    initial begin
        board = new();
        board.clear_state();
        repeat (7) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // Directed: first sample, extremes, zero blend, rejected and restart counters.
        send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0000, 32'd5, 0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 32'd6, 0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd7, 0);
        send_sample(16'h8000, 16'h7fff, 16'h0001, 16'hffff, 32'd8, 0);
        send_sample(16'h1234, 16'h0000, 16'h0000, 16'h0000, 32'd8, 0);
        send_sample(16'h1234, 16'h0000, 16'h0000, 16'h0000, 32'h7fffffff, 0);
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0400, 32'h80000000, 0);
        send_sample(16'h0100, 16'h0200, 16'h0300, 16'h0400, 32'd2000, 0);
        drain();
        write_cfg(REG_ALPHA, 31'd65535);
        write_cfg(REG_FLOOR, 31'h7fffffff);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd1, 0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001, 32'd1, 0);
        send_sample(16'hc000, 16'h2000, 16'h0000, 16'h0000, 32'hffffffff, 0);
        drain();
        write_cfg(REG_ALPHA, 31'd0);
        write_cfg(REG_FLOOR, 31'd0);
        send_sample(16'h2000, 16'h2000, 16'h2000, 16'h2000, 32'd100, 0);
        send_sample(16'h2000, 16'h2000, 16'h2000, 16'h2000, 32'd99, 0);
        drain();

        seq_now = 100;
        write_cfg(REG_ALPHA, 31'd58982);
        write_cfg(REG_FLOOR, 31'd1000);
        hold_off_req = 1;
        random_phase(400, 0);
        drain();
        write_cfg(REG_ALPHA, 31'($urandom_range(0, 65535)));
        write_cfg(REG_FLOOR, 31'($urandom()));
        random_phase(400, 1);
        drain();
        write_cfg(REG_ALPHA, 31'd32768);
        write_cfg(REG_FLOOR, 31'd0);
        random_phase(350, 1);
        drain();
        write_cfg(REG_ALPHA, 31'd1);
        write_cfg(REG_FLOOR, 31'd50);
        random_phase(350, 1);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        idle_cycles = 0;
        hold_off_req = 0;
        seq_now = 0;
    end
endmodule

// File: files.f
src/qsf_pkg.sv
src/qsf_front.sv
src/qsf_back.sv
src/quaternion_smoothing_filter_unit.sv
bench/tb_quaternion_smoothing_filter_unit.sv
